@@ rtl/core/lbp3x3_pkg.sv @@
// Shared types and constants of the 3x3 local binary pattern unit.
// Used by the top level and its port checker; depends on nothing else.
`timescale 1ns / 1ps

package lbp3x3_pkg;

  localparam int PIX_W   = 8;
  localparam int CODE_W  = 8;
  localparam int FW_W    = 11;
  localparam int FH_W    = 12;
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 1;

  typedef logic [PIX_W-1:0]     pix_t;
  typedef logic [CODE_W-1:0]    code_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_FRAME_WIDTH  = 1'b0;
  localparam cfg_idx_t REG_FRAME_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd230;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd270;
  localparam int MIN_DIM = 3;

endpackage

@@ rtl/core/lbp_3x3_operator_unit.sv @@
// Top level of the 3x3 local binary pattern unit: line stores, window and code logic.
// Depends on lbp3x3_pkg.
`timescale 1ns / 1ps

// Takes one 8-bit gray pixel per clock in raster order and returns one 8-bit LBP
// code for every interior pixel, with tlast on the last code of a frame. A pixel
// is accepted every cycle while the result side keeps up; the code that a pixel
// completes is registered when that pixel leaves the processing register. The
// line stores are two MAX_WIDTH x 8 memories, each read once at pixel transfer
// and written once when that pixel leaves the processing register. Their
// contents need no clearing after reset. Frame size must be written on the
// configuration port between frames; the block itself does not enforce this.
module lbp_3x3_operator_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] pixel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [7:0]                         out_tdata,  // [7:0] pattern_code
  output logic                               out_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  lbp3x3_pkg::cfg_idx_t               cfg_index,
  input  logic [lbp3x3_pkg::CFG_W-1:0]       cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = (AW >= 11) ? AW + 1 : 12;
  localparam int HW = lbp3x3_pkg::FH_W + 1;
  localparam logic [WW-1:0] MAX_W = WW'(MAX_WIDTH);

  logic [lbp3x3_pkg::FW_W-1:0] fw_r;
  logic [lbp3x3_pkg::FH_W-1:0] fh_r;

  lbp3x3_pkg::pix_t upper_mem [MAX_WIDTH];
  lbp3x3_pkg::pix_t middle_mem [MAX_WIDTH];

  logic [AW-1:0]                 col_r, col_nxt;
  logic [lbp3x3_pkg::FH_W-1:0]   row_r, row_nxt;

  logic                          s1_valid_r;
  logic                          s1_emit_r;
  logic                          s1_last_r;
  logic [AW-1:0]                 s1_addr_r;
  lbp3x3_pkg::pix_t              s1_pix_r;
  lbp3x3_pkg::pix_t              rd_upper_r;
  lbp3x3_pkg::pix_t              rd_middle_r;
  lbp3x3_pkg::pix_t              win_r [6];

  logic                          out_valid_r;
  lbp3x3_pkg::code_t             out_code_r;
  logic                          out_last_r;

  logic [WW-1:0]                 fw_ext, eff_w, col_ext;
  logic [HW-1:0]                 eff_h, row_ext;
  logic                          row_end, frame_end, emit;
  logic                          in_xfer, s1_go;
  lbp3x3_pkg::pix_t              ctr;
  lbp3x3_pkg::code_t             code;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= lbp3x3_pkg::FRAME_WIDTH_RST;
      fh_r <= lbp3x3_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lbp3x3_pkg::REG_FRAME_WIDTH:  fw_r <= cfg_data[lbp3x3_pkg::FW_W-1:0];
        lbp3x3_pkg::REG_FRAME_HEIGHT: fh_r <= cfg_data[lbp3x3_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fw_ext = WW'(fw_r);
    if (fw_ext > MAX_W) begin
      eff_w = MAX_W;
    end else if (fw_ext < WW'(lbp3x3_pkg::MIN_DIM)) begin
      eff_w = WW'(lbp3x3_pkg::MIN_DIM);
    end else begin
      eff_w = fw_ext;
    end
    eff_h = (fh_r < lbp3x3_pkg::FH_W'(lbp3x3_pkg::MIN_DIM)) ?
            HW'(lbp3x3_pkg::MIN_DIM) : HW'(fh_r);
    col_ext   = WW'(col_r) + WW'(1);
    row_ext   = HW'(row_r) + HW'(1);
    row_end   = (col_ext >= eff_w);
    frame_end = row_end && (row_ext >= eff_h);
    emit      = (row_r >= lbp3x3_pkg::FH_W'(2)) && (col_r >= AW'(2));
    if (frame_end) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (row_end) begin
      col_nxt = '0;
      row_nxt = row_r + lbp3x3_pkg::FH_W'(1);
    end else begin
      col_nxt = col_r + AW'(1);
      row_nxt = row_r;
    end
  end

  assign s1_go     = s1_valid_r && (!s1_emit_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_emit_r   <= emit;
      s1_last_r   <= frame_end;
      s1_addr_r   <= col_r;
      s1_pix_r    <= in_tdata;
      rd_upper_r  <= upper_mem[col_r];
      rd_middle_r <= middle_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      upper_mem[s1_addr_r]  <= rd_middle_r;
      middle_mem[s1_addr_r] <= s1_pix_r;
    end
  end

  assign ctr = win_r[2];

  always_comb begin
    code[7] = (win_r[1]    >= ctr);
    code[6] = (win_r[0]    >= ctr);
    code[5] = (rd_upper_r  >= ctr);
    code[4] = (rd_middle_r >= ctr);
    code[3] = (s1_pix_r    >= ctr);
    code[2] = (win_r[4]    >= ctr);
    code[1] = (win_r[5]    >= ctr);
    code[0] = (win_r[3]    >= ctr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_go) begin
      win_r[1] <= win_r[0];
      win_r[0] <= rd_upper_r;
      win_r[3] <= win_r[2];
      win_r[2] <= rd_middle_r;
      win_r[5] <= win_r[4];
      win_r[4] <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit_r) begin
      out_code_r <= code;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_code_r;
  assign out_tlast  = out_last_r;

endmodule

@@ rtl/core/lbp3x3_checker.sv @@
// Port-level checker of the 3x3 local binary pattern unit and its bind to the top level.
// Depends on lbp3x3_pkg and lbp_3x3_operator_unit.
`timescale 1ns / 1ps

module lbp3x3_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [7:0]                   out_tdata,
  input logic                         out_tlast,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input lbp3x3_pkg::cfg_idx_t         cfg_index
);

  // A held result must not block new pixels when the output side is empty.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while no result is pending");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // Configuration is never back-pressured, so a write transfers on every valid cycle.
  a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && (cfg_index == lbp3x3_pkg::REG_FRAME_WIDTH ||
                  cfg_index == lbp3x3_pkg::REG_FRAME_HEIGHT) |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind lbp_3x3_operator_unit lbp3x3_checker u_lbp3x3_checker (.*);
